// ----- hw/rtl/wpet_pkg.sv -----
// shared constants and types for the widest-path edge table
`timescale 1ns / 1ps
package wpet_pkg;
	localparam int MaxNodes = 16;
	localparam int NodeBits = 4;
	localparam int CellBits = 8;
	localparam int WeightBits = 16;
	localparam int CountBits = 5;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_DEL   = 2'd1,
		MODE_QUERY = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_NODE = 3'd1,
		ST_SELF     = 3'd2,
		ST_EXISTS   = 3'd3,
		ST_NO_EDGE  = 3'd4,
		ST_NO_PATH  = 3'd5
	} status_t;
endpackage

// ----- hw/rtl/wpet_ram.sv -----
// generic single-port ram with registered read
`timescale 1ns / 1ps
module wpet_ram #(
	parameter int Width = 16,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ----- hw/rtl/widest_path_edge_table.sv -----
// widest-path edge table: edge add, delete and bottleneck query over an adjacency matrix
// add: check, then mirror write or stored-weight read, then output; delete, unused mode, bad node
//   or equal query nodes: check, then output; query: per visited node one max-select pass plus one
//   relax pass over the weight ram; one word at a time, not ready meanwhile
// reset (arst_n low) clears presence bits, node_count and the control state at once;
//   weight ram is not cleared and is only read behind a set presence bit
`timescale 1ns / 1ps
module widest_path_edge_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [3:0]  node_a,
	input  logic [3:0]  node_b,
	input  logic [15:0] weight,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] value
);
	localparam int N = wpet_pkg::MaxNodes;
	localparam int NB = wpet_pkg::NodeBits;
	localparam int WB = wpet_pkg::WeightBits;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_ADD_RD, S_ADD_WR2, S_SEL, S_SEL_END, S_REL, S_OUT
	} state_t;

	state_t state_q;
	logic [wpet_pkg::CountBits-1:0] count_q;
	logic [N*N-1:0] present_q;
	logic [1:0] mode_q;
	logic [NB-1:0] a_q, b_q;
	logic [WB-1:0] w_q;
	logic [2:0] status_q;
	logic [WB-1:0] value_q;
	logic [WB:0] best_q [N];
	logic [N-1:0] reached_q, visited_q;
	logic [NB-1:0] i_q, u_q;
	logic found_q;
	logic [NB:0] rel_q;
	logic [NB-1:0] rel_idx_s1;
	logic rel_v_s1;

	logic ram_we;
	logic [wpet_pkg::CellBits-1:0] ram_addr;
	logic [WB-1:0] ram_wdata, ram_rdata;

	logic [NB:0] live_n;
	assign live_n = (count_q > 5'(N)) ? 5'(N) : count_q;

	wpet_ram #(.Width(WB), .Depth(N*N)) u_weight (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	always_comb begin
		ram_we = 1'b0;
		ram_wdata = w_q;
		unique case (state_q)
			S_CHECK: begin
				ram_addr = {a_q, b_q};
				ram_we = (mode_q == wpet_pkg::MODE_ADD) && (a_q != b_q)
					&& !present_q[{a_q, b_q}] && ({1'b0, a_q} < live_n)
					&& ({1'b0, b_q} < live_n);
			end
			S_ADD_WR2: begin
				ram_addr = {b_q, a_q};
				ram_we = 1'b1;
			end
			S_REL: ram_addr = {u_q, rel_q[NB-1:0]};
			default: ram_addr = {a_q, b_q};
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status = status_q;
	assign value = value_q;

	logic [WB:0] m_c;
	always_comb begin
		m_c = (best_q[u_q] < {1'b0, ram_rdata}) ? best_q[u_q] : {1'b0, ram_rdata};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			present_q <= '0;
			reached_q <= '0;
			visited_q <= '0;
			found_q <= 1'b0;
			rel_v_s1 <= 1'b0;
		end else begin
			if (cfg_we) count_q <= cfg_wdata;
			rel_v_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q <= mode;
						a_q <= node_a;
						b_q <= node_b;
						w_q <= weight;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					value_q <= '0;
					status_q <= wpet_pkg::ST_OK;
					state_q <= S_OUT;
					if (mode_q == wpet_pkg::MODE_NONE) begin
						status_q <= wpet_pkg::ST_OK;
					end else if (({1'b0, a_q} >= live_n) || ({1'b0, b_q} >= live_n)) begin
						status_q <= wpet_pkg::ST_BAD_NODE;
					end else if (mode_q == wpet_pkg::MODE_ADD) begin
						if (a_q == b_q) begin
							status_q <= wpet_pkg::ST_SELF;
						end else if (present_q[{a_q, b_q}]) begin
							status_q <= wpet_pkg::ST_EXISTS;
							state_q <= S_ADD_RD;
						end else begin
							present_q[{a_q, b_q}] <= 1'b1;
							present_q[{b_q, a_q}] <= 1'b1;
							state_q <= S_ADD_WR2;
						end
					end else if (mode_q == wpet_pkg::MODE_DEL) begin
						if (present_q[{a_q, b_q}] || present_q[{b_q, a_q}]) begin
							present_q[{a_q, b_q}] <= 1'b0;
							present_q[{b_q, a_q}] <= 1'b0;
						end else begin
							status_q <= wpet_pkg::ST_NO_EDGE;
						end
					end else if (a_q != b_q) begin
						// query: seed start node
						reached_q <= '0;
						visited_q <= '0;
						reached_q[a_q] <= 1'b1;
						best_q[a_q] <= {1'b1, {WB{1'b0}}};
						i_q <= '0;
						found_q <= 1'b0;
						state_q <= S_SEL;
					end
				end
				S_ADD_RD: begin
					value_q <= ram_rdata;
					state_q <= S_OUT;
				end
				S_ADD_WR2: state_q <= S_OUT;
				S_SEL: begin
					if ((5'(i_q) < live_n) && reached_q[i_q] && !visited_q[i_q]
						&& (!found_q || best_q[i_q] > best_q[u_q])) begin
						u_q <= i_q;
						found_q <= 1'b1;
					end
					i_q <= i_q + 1'b1;
					if (i_q == NB'(N-1)) state_q <= S_SEL_END;
				end
				S_SEL_END: begin
					if (!found_q) begin
						status_q <= wpet_pkg::ST_NO_PATH;
						state_q <= S_OUT;
					end else if (u_q == b_q) begin
						visited_q[u_q] <= 1'b1;
						value_q <= best_q[u_q][WB-1:0];
						state_q <= S_OUT;
					end else begin
						visited_q[u_q] <= 1'b1;
						rel_q <= '0;
						state_q <= S_REL;
					end
				end
				S_REL: begin
					// address issued this cycle, data used next cycle
					rel_idx_s1 <= rel_q[NB-1:0];
					rel_v_s1 <= (rel_q < 5'(N)) && (rel_q < live_n);
					rel_q <= rel_q + 1'b1;
					if (rel_v_s1 && present_q[{u_q, rel_idx_s1}] && !visited_q[rel_idx_s1]
						&& (!reached_q[rel_idx_s1] || m_c > best_q[rel_idx_s1])) begin
						best_q[rel_idx_s1] <= m_c;
						reached_q[rel_idx_s1] <= 1'b1;
					end
					if (rel_q == 5'(N)) begin
						i_q <= '0;
						found_q <= 1'b0;
						state_q <= S_SEL;
					end
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the widest-path edge table
`timescale 1ns / 1ps
module tb_top;
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [3:0]  node_a;
	logic [3:0]  node_b;
	logic [15:0] weight;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [15:0] value;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] value;
	} answer_t;

	// shadow graph
	logic        link_on [wpet_pkg::MaxNodes][wpet_pkg::MaxNodes];
	logic [15:0] link_w [wpet_pkg::MaxNodes][wpet_pkg::MaxNodes];
	logic [4:0]  slots;

	// expected words in order of sending
	answer_t answers_due [4096];
	int      due_wr;
	int      due_rd;
	int      err_count;
	bit      hold_off;
	int      stall_mode; // 0 random, 1 never stall
	int      rx_wait;

	widest_path_edge_table dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .node_a(node_a),
		.node_b(node_b), .weight(weight), .out_valid(out_valid),
		.out_ready(out_ready), .status(status), .value(value)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic answer_t widest(logic [3:0] s, logic [3:0] e, int n);
		logic        reached [wpet_pkg::MaxNodes];
		logic        done [wpet_pkg::MaxNodes];
		logic [16:0] best [wpet_pkg::MaxNodes];
		logic [16:0] m;
		answer_t     r;
		int          u;
		bit          found;
		for (int i = 0; i < wpet_pkg::MaxNodes; i++) begin
			reached[i] = 0;
			done[i] = 0;
			best[i] = 0;
		end
		best[s] = 17'h10000;
		reached[s] = 1;
		r.status = wpet_pkg::ST_NO_PATH;
		r.value = 0;
		for (int p = 0; p < n; p++) begin
			u = 0;
			found = 0;
			for (int i = 0; i < n; i++)
				if (reached[i] && !done[i] && (!found || best[i] > best[u])) begin
					u = i;
					found = 1;
				end
			if (!found) break;
			done[u] = 1;
			if (u == e) begin
				r.status = wpet_pkg::ST_OK;
				r.value = best[u][15:0];
				return r;
			end
			for (int i = 0; i < n; i++)
				if (link_on[u][i] && !done[i]) begin
					m = (best[u] < {1'b0, link_w[u][i]}) ? best[u] : {1'b0, link_w[u][i]};
					if (!reached[i] || m > best[i]) begin
						best[i] = m;
						reached[i] = 1;
					end
				end
		end
		return r;
	endfunction

	function automatic answer_t apply_item(logic [1:0] md, logic [3:0] a, logic [3:0] b,
			logic [15:0] w);
		answer_t r;
		int      n;
		n = (slots > wpet_pkg::MaxNodes) ? wpet_pkg::MaxNodes : int'(slots);
		r.status = wpet_pkg::ST_OK;
		r.value = 0;
		if (md == wpet_pkg::MODE_NONE) return r;
		if (a >= n || b >= n) begin
			r.status = wpet_pkg::ST_BAD_NODE;
			return r;
		end
		case (md)
			wpet_pkg::MODE_ADD: begin
				if (a == b) r.status = wpet_pkg::ST_SELF;
				else if (link_on[a][b]) begin
					r.status = wpet_pkg::ST_EXISTS;
					r.value = link_w[a][b];
				end else begin
					link_on[a][b] = 1;
					link_on[b][a] = 1;
					link_w[a][b] = w;
					link_w[b][a] = w;
				end
			end
			wpet_pkg::MODE_DEL: begin
				if (link_on[a][b] || link_on[b][a]) begin
					link_on[a][b] = 0;
					link_on[b][a] = 0;
				end else r.status = wpet_pkg::ST_NO_EDGE;
			end
			default: begin
				if (a != b) r = widest(a, b, n);
			end
		endcase
		return r;
	endfunction

	// valid stays up after the accepting edge unless a gap or a drain follows
	task automatic send_word(logic [1:0] md, logic [3:0] a, logic [3:0] b, logic [15:0] w);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		answers_due[due_wr] = apply_item(md, a, b, w);
		due_wr++;
		in_valid <= 1'b1;
		mode <= md;
		node_a <= a;
		node_b <= b;
		weight <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		err_count++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (due_rd != due_wr) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_slots(logic [4:0] n);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		slots = n;
	endtask

	// result checker
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_rd == due_wr) begin
				report_mismatch("unexpected word", int'(status), -1);
			end else begin
				want = answers_due[due_rd];
				due_rd++;
				if (status !== want.status)
					report_mismatch("status", int'(status), int'(want.status));
				if (value !== want.value)
					report_mismatch("value", int'(value), int'(want.value));
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (!arst_n || hold_off) begin
			out_ready <= 1'b0;
			rx_wait = 0;
		end else if (stall_mode == 1) begin
			out_ready <= 1'b1;
		end else if (rx_wait > 0) begin
			out_ready <= 1'b0;
			rx_wait--;
		end else begin
			rx_wait = gap_len();
			if (rx_wait == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				rx_wait--;
			end
		end
	end

	task automatic test_directed();
		set_slots(5'd4);
		send_word(wpet_pkg::MODE_ADD, 4'd0, 4'd1, 16'hffff);
		send_word(wpet_pkg::MODE_ADD, 4'd1, 4'd0, 16'd5);
		send_word(wpet_pkg::MODE_ADD, 4'd2, 4'd2, 16'd7);
		send_word(wpet_pkg::MODE_ADD, 4'd1, 4'd2, 16'd0);
		send_word(wpet_pkg::MODE_ADD, 4'd4, 4'd0, 16'd1);
		send_word(wpet_pkg::MODE_ADD, 4'd0, 4'd15, 16'd1);
		send_word(wpet_pkg::MODE_QUERY, 4'd0, 4'd2, 16'd0);
		send_word(wpet_pkg::MODE_QUERY, 4'd0, 4'd1, 16'd0);
		send_word(wpet_pkg::MODE_QUERY, 4'd3, 4'd3, 16'd0);
		send_word(wpet_pkg::MODE_QUERY, 4'd0, 4'd3, 16'd0);
		send_word(wpet_pkg::MODE_QUERY, 4'd15, 4'd0, 16'd0);
		send_word(wpet_pkg::MODE_DEL, 4'd2, 4'd2, 16'd0);
		send_word(wpet_pkg::MODE_DEL, 4'd0, 4'd3, 16'd0);
		send_word(wpet_pkg::MODE_DEL, 4'd1, 4'd0, 16'd0);
		send_word(wpet_pkg::MODE_NONE, 4'd15, 4'd15, 16'hffff);
		send_word(wpet_pkg::MODE_QUERY, 4'd0, 4'd2, 16'd0);
		set_slots(5'd0);
		send_word(wpet_pkg::MODE_ADD, 4'd0, 4'd1, 16'd3);
		set_slots(5'd16);
		send_word(wpet_pkg::MODE_ADD, 4'd15, 4'd14, 16'h8000);
		send_word(wpet_pkg::MODE_QUERY, 4'd14, 4'd15, 16'd0);
		set_slots(5'd31);
		send_word(wpet_pkg::MODE_ADD, 4'd0, 4'd15, 16'h1234);
		send_word(wpet_pkg::MODE_QUERY, 4'd15, 4'd1, 16'd0);
		set_slots(5'd2);
		send_word(wpet_pkg::MODE_QUERY, 4'd0, 4'd1, 16'd0);
	endtask

	task automatic test_random(int count, logic [4:0] n);
		int r;
		int lim;
		set_slots(n);
		lim = (n == 0) ? 0 : ((n > 16) ? 15 : n - 1);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				send_word(2'($urandom), 4'($urandom), 4'($urandom), 16'($urandom));
			else if (r < 50)
				send_word(wpet_pkg::MODE_ADD, 4'($urandom_range(0, lim)),
					4'($urandom_range(0, lim)), 16'($urandom));
			else if (r < 65)
				send_word(wpet_pkg::MODE_DEL, 4'($urandom_range(0, lim)),
					4'($urandom_range(0, lim)), 16'($urandom));
			else
				send_word(wpet_pkg::MODE_QUERY, 4'($urandom_range(0, lim)),
					4'($urandom_range(0, lim)), 16'($urandom));
		end
	endtask

	task automatic test_backpressure();
		drain();
		fork
			begin
				hold_off = 1;
				repeat (1500) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 8; i++)
				send_word(wpet_pkg::MODE_ADD, 4'(i), 4'(i + 1), 16'($urandom));
		join
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		mode = '0;
		node_a = '0;
		node_b = '0;
		weight = '0;
		err_count = 0;
		due_wr = 0;
		due_rd = 0;
		hold_off = 0;
		stall_mode = 0;
		slots = 0;
		for (int i = 0; i < wpet_pkg::MaxNodes; i++)
			for (int j = 0; j < wpet_pkg::MaxNodes; j++) begin
				link_on[i][j] = 0;
				link_w[i][j] = 0;
			end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(150, 5'd6);
		stall_mode = 1;
		test_random(150, 5'd16);
		stall_mode = 0;
		test_backpressure();
		test_random(150, 5'd3);
		test_random(150, 5'd10);
		test_random(150, 5'd16);
		drain();
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
